### hw/rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

    localparam int DQ_DEPTH      = 16;
    localparam int DQ_DATA_WIDTH = 32;
    localparam int WORD_W        = 32;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

### hw/rtl/double_ended_queue.sv
// Bounded double-ended queue: circular entry memory with front/back pointers and a count.
// An accepted item's result is written into the output register in the following cycle.
// Throughput: one item per cycle unless out_ready stalls; the single entry memory port
// does one write (push) or registered read (pop) per item; pointers update in the same cycle.
// Reset: rst_n clears pointers, count and output valid; entry memory contents are
// not cleared and are only read after being written.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH,
    localparam int CNT_W     = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mode_t             mode,
    input  logic [WORD_W-1:0] value_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] value_out,
    output status_t           status,
    output logic [CNT_W-1:0]  count,
    output logic              is_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int SW    = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    logic [SW-1:0]    mem [DEPTH];
    logic [SW-1:0]    out_value_reg;

    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    status_t          out_status_reg, status_next;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_empty_reg;

    logic             accept;
    logic             full, empty;
    logic [PTR_W-1:0] front_dec, front_inc, back_dec, back_inc;
    logic             wr_en, rd_en;
    logic [PTR_W-1:0] wr_addr, rd_addr;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == FULLC);
    assign empty    = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? LAST : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST) ? '0 : front_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? LAST : back_reg - 1'b1;
    assign back_inc  = (back_reg == LAST) ? '0 : back_reg + 1'b1;

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = STATUS_DONE;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = back_reg;
        rd_addr     = front_reg;
        case (mode)
            MODE_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    back_next  = back_inc;
                    wr_en      = 1'b1;
                    wr_addr    = back_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    rd_en      = 1'b1;
                    rd_addr    = front_reg;
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    back_next  = back_dec;
                    rd_en      = 1'b1;
                    rd_addr    = back_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    // entry memory; its read register doubles as the value output register
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[wr_addr] <= value_in[SW-1:0];
        end
        if (accept)
        begin
            if (rd_en)
            begin
                out_value_reg <= mem[rd_addr];
            end
            else
            begin
                out_value_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            back_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_DONE;
            out_count_reg  <= '0;
            out_empty_reg  <= 1'b1;
        end
        else if (accept)
        begin
            front_reg      <= front_next;
            back_reg       <= back_next;
            count_reg      <= count_next;
            out_valid_reg  <= 1'b1;
            out_status_reg <= status_next;
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = WORD_W'(out_value_reg);
    assign status    = out_status_reg;
    assign count     = out_count_reg;
    assign is_empty  = out_empty_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULLC)
        else $error("entry count above depth");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_empty_reg == (out_count_reg == '0)))
        else $error("empty flag disagrees with count");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK))
        |=> (out_status_reg == STATUS_FULL && $stable(count_reg)
             && $stable(front_reg) && $stable(back_reg)))
        else $error("push on full queue changed state");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STATUS_EMPTY)
        |-> (out_value_reg == '0 && out_count_reg == '0))
        else $error("pop on empty queue returned data");

endmodule
